@@ rtl/stable_priority_queue_top_defines.svh @@
// Assertion macros shared by the checker of the stable priority queue.
// No dependencies; the including file supplies signals named clk and rst_n.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stable priority queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stable priority queue check failed");

`endif

@@ rtl/spq_pkg.sv @@
// Package of the stable priority queue: port widths, command codes and the
// command struct sent to every cell. No dependencies.
package spq_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int IN_PRIO_W  = 8;
  localparam int OUT_DATA_W = 32;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } spq_kind_e;

  // Queue operation applied to the whole row of cells in the same cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

@@ rtl/spq_if.sv @@
// Valid/ready channel interfaces of the stable priority queue.
// Depends on spq_pkg for the payload widths.
interface spq_in_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [IN_DATA_W-1:0] item_data;
  logic [IN_PRIO_W-1:0] item_priority;

  modport source (output valid, kind, item_data, item_priority, input ready);
  modport sink   (input valid, kind, item_data, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_valid;
  logic                  out_dropped;

  modport source (output valid, out_data, out_valid, out_dropped, input ready);
  modport sink   (input valid, out_data, out_valid, out_dropped, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted shift-register queue.
// Depends on spq_pkg for the command struct.
module spq_cell #(
  parameter int DATA_BITS     = 32,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_pkg::spq_cmd_t        cmd,
  input  logic [DATA_BITS-1:0]     new_data,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic                     left_valid,
  input  logic                     left_stay,
  input  logic [DATA_BITS-1:0]     left_data,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic                     right_valid,
  input  logic [DATA_BITS-1:0]     right_data,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic                     valid,
  output logic                     stay,
  output logic [DATA_BITS-1:0]     data,
  output logic [PRIORITY_BITS-1:0] prio
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [DATA_BITS-1:0]     data_r, data_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // An entry stays put on a push when it is at least as urgent as the new one,
  // which keeps equal priorities in arrival order.
  assign stay  = valid_r && (prio_r <= new_prio);
  assign valid = valid_r;
  assign data  = data_r;
  assign prio  = prio_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (cmd.push) begin
      valid_nxt = valid_r || left_valid;
      if (!stay) begin
        if (left_stay) begin
          data_nxt = new_data;
          prio_nxt = new_prio;
        end else begin
          data_nxt = left_data;
          prio_nxt = left_prio;
        end
      end
    end else if (cmd.pop) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

endmodule

@@ rtl/stable_priority_queue_top.sv @@
// Stable bounded priority queue built as a row of QUEUE_DEPTH sorted cells.
// It takes one push or pop transaction per clock cycle unless the output is
// stalled: every cell compares the new priority with its own entry in
// parallel and shifts by at most one place, so the row is sorted again at
// the next edge. The result of each transaction appears in an output
// register in the cycle after acceptance, and a new transaction is taken
// while that result waits, unless it is stalled. Pushes to a full queue are
// dropped and flagged; pops on an empty queue return out_valid low with zero
// data. No clearing pass follows reset. Depends on spq_pkg, spq_if, spq_cell.
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int DATA_BITS     = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_if,
  spq_out_if.source  out_if
);
  import spq_pkg::*;

  logic [DATA_BITS-1:0]     new_data;
  logic [PRIORITY_BITS-1:0] new_prio;
  spq_cmd_t                 cmd;
  logic                     accept;
  logic                     full;
  logic                     head_valid;

  logic                     cell_valid [QUEUE_DEPTH];
  logic                     cell_stay  [QUEUE_DEPTH];
  logic [DATA_BITS-1:0]     cell_data  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];

  logic                  res_vld_r, res_vld_nxt;
  logic [OUT_DATA_W-1:0] res_data_r, res_data_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic                  res_dropped_r, res_dropped_nxt;

  assign new_data   = DATA_BITS'(in_if.item_data);
  assign new_prio   = PRIORITY_BITS'(in_if.item_priority);
  assign in_if.ready = !res_vld_r || out_if.ready;
  assign accept     = in_if.valid && in_if.ready;
  assign full       = cell_valid[QUEUE_DEPTH-1];
  assign head_valid = cell_valid[0];

  assign cmd.push = accept && (in_if.kind == KIND_PUSH) && !full;
  assign cmd.pop  = accept && (in_if.kind == KIND_POP) && head_valid;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     l_valid, l_stay, r_valid;
    logic [DATA_BITS-1:0]     l_data, r_data;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      // The head sees a virtual neighbor that always stays, so it takes the
      // new entry whenever its own entry moves down.
      assign l_valid = 1'b1;
      assign l_stay  = 1'b1;
      assign l_data  = new_data;
      assign l_prio  = new_prio;
    end else begin : g_body
      assign l_valid = cell_valid[i-1];
      assign l_stay  = cell_stay[i-1];
      assign l_data  = cell_data[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_data  = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_data  = cell_data[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_BITS     (DATA_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_data    (new_data),
      .new_prio    (new_prio),
      .left_valid  (l_valid),
      .left_stay   (l_stay),
      .left_data   (l_data),
      .left_prio   (l_prio),
      .right_valid (r_valid),
      .right_data  (r_data),
      .right_prio  (r_prio),
      .valid       (cell_valid[i]),
      .stay        (cell_stay[i]),
      .data        (cell_data[i]),
      .prio        (cell_prio[i])
    );
  end

  always_comb begin
    res_vld_nxt     = res_vld_r;
    res_data_nxt    = res_data_r;
    res_valid_nxt   = res_valid_r;
    res_dropped_nxt = res_dropped_r;
    if (res_vld_r && out_if.ready) begin
      res_vld_nxt = 1'b0;
    end
    if (accept) begin
      res_vld_nxt     = 1'b1;
      res_data_nxt    = cmd.pop ? OUT_DATA_W'(cell_data[0]) : '0;
      res_valid_nxt   = cmd.pop;
      res_dropped_nxt = (in_if.kind == KIND_PUSH) && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
    end
    res_data_r    <= res_data_nxt;
    res_valid_r   <= res_valid_nxt;
    res_dropped_r <= res_dropped_nxt;
  end

  assign out_if.valid       = res_vld_r;
  assign out_if.out_data    = res_data_r;
  assign out_if.out_valid   = res_valid_r;
  assign out_if.out_dropped = res_dropped_r;

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks of the stable priority queue and their bind.
// Depends on spq_pkg and stable_priority_queue_top_defines.svh.
`include "stable_priority_queue_top_defines.svh"

module spq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_vld,
  input logic                           out_ready,
  input logic [spq_pkg::OUT_DATA_W-1:0] out_data,
  input logic                           out_valid,
  input logic                           out_dropped
);
  import spq_pkg::*;

  // A result can report a popped entry or a dropped push, never both.
  `SPQ_ASSERT_SAME(a_valid_not_dropped, out_vld, !(out_valid && out_dropped))
  // Data is zero on every result that did not return an entry.
  `SPQ_ASSERT_SAME(a_zero_data, out_vld && !out_valid, out_data == '0)
  // Every accepted transaction shows its result in the next cycle.
  `SPQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_vld)
  // A stalled result holds its payload.
  `SPQ_ASSERT_NEXT(a_stall_holds, out_vld && !out_ready,
                   out_vld && $stable(out_data) && $stable(out_valid))

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_vld     (out_if.valid),
  .out_ready   (out_if.ready),
  .out_data    (out_if.out_data),
  .out_valid   (out_if.out_valid),
  .out_dropped (out_if.out_dropped)
);
